/* src/rspe_pkg.sv */
// package for the reed-solomon parity encoder: field constants, word types,
// gf(256) multiply and generator coefficients built at elaboration
// no dependencies
`default_nettype none

package rspe_pkg;

  // number of lfsr stages (parity bytes per chunk)
  localparam int unsigned PARITY_BYTES = 4;
  // parity bytes carried in the result word
  localparam int unsigned OUT_PARITY   = 4;

  localparam logic [8:0] FIELD_POLY   = 9'h165;
  localparam logic [7:0] LENGTH_RESET = 8'd239;
  localparam logic [8:0] COUNT_LIMIT  = 9'd255;
  localparam logic [7:0] ALPHA        = 8'h02;

  typedef logic [7:0] byte_t;
  typedef byte_t [PARITY_BYTES-1:0] parity_t;
  typedef byte_t [PARITY_BYTES:0]   gen_t;
  typedef byte_t [OUT_PARITY-1:0]   out_parity_t;

  // gf(256) multiply, shift-and-add with reduction by the field polynomial
  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    logic [8:0] x;
    byte_t      acc;
    x   = {1'b0, a};
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc ^= x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x ^= FIELD_POLY;
      end
    end
    return acc;
  endfunction

  // generator polynomial: product of (x - alpha^i), i = 0 .. PARITY_BYTES-1
  function automatic gen_t build_gen();
    gen_t  g;
    byte_t root;
    g    = '0;
    g[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < PARITY_BYTES; i++) begin
      for (int j = i + 1; j > 0; j--) begin
        g[j] ^= gf_mul(g[j-1], root);
      end
      root = gf_mul(root, ALPHA);
    end
    return g;
  endfunction

  localparam gen_t GEN_COEF = build_gen();

endpackage

`default_nettype wire

/* src/rspe_in_if.sv */
// input channel interface: one data word per handshake
// depends on rspe_pkg
`default_nettype none

interface rspe_in_if
  import rspe_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

/* src/rspe_out_if.sv */
// result channel interface: parity bytes and chunk size per word
// depends on rspe_pkg
`default_nettype none

interface rspe_out_if
  import rspe_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t parity_first;
  byte_t parity_second;
  byte_t parity_third;
  byte_t parity_fourth;
  byte_t chunk_bytes;

  modport source (output valid, output parity_first, output parity_second,
                  output parity_third, output parity_fourth, output chunk_bytes,
                  input ready);
  modport sink   (input valid, input parity_first, input parity_second,
                  input parity_third, input parity_fourth, input chunk_bytes,
                  output ready);
endinterface

`default_nettype wire

/* src/reed_solomon_parity_encoder.sv */
// top level of the reed-solomon parity encoder over gf(256)
// depends on rspe_pkg, rspe_in_if, rspe_out_if and rspe_lfsr
//
// usage:
//   in_i carries one data word (data_byte, end_of_file) per handshake.
//   out_o carries one result word per closed chunk: four parity bytes,
//   first stage first, and chunk_bytes, the bytes covered.
//   a chunk closes after the byte that brings its count to chunk_length
//   (a value of zero acts as one), after a byte with end_of_file set, or
//   at 255 bytes.
//   cfg_we_i / cfg_wdata_i write chunk_length; write it only
//   while no word is in flight. the new length applies from the next byte.
// timing:
//   one word per cycle while the result channel keeps up. a word is registered
//   at the input, run through the combinational lfsr step and, if it closes
//   a chunk, lands in the result register as it leaves the input register,
//   which raises out_o.valid.
// reset and stall:
//   rst_ni clears parity, count and both valid flags and sets chunk_length
//   to 239. while the receiver stalls, words that close no chunk keep
//   flowing; a closing word waits in the input register, and in_i.ready
//   drops once that register is full and cannot drain.
`default_nettype none

module reed_solomon_parity_encoder
  import rspe_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire byte_t  cfg_wdata_i,
  rspe_in_if.sink     in_i,
  rspe_out_if.source  out_o
);

  byte_t       chunk_length_q;
  logic        in_valid_q;
  byte_t       in_data_q;
  logic        in_eof_q;
  parity_t     parity_q;
  parity_t     parity_step;
  byte_t       count_q;
  logic [8:0]  count_next;
  logic        chunk_close;
  logic        advance;
  logic        out_valid_q;
  out_parity_t out_parity_d;
  out_parity_t out_parity_q;
  byte_t       out_bytes_q;

  // chunk length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_length_q <= LENGTH_RESET;
    end else if (cfg_we_i) begin
      chunk_length_q <= cfg_wdata_i;
    end
  end

  // close test on the word held in the input register
  assign count_next  = {1'b0, count_q} + 9'd1;
  assign chunk_close = in_eof_q || (count_next >= COUNT_LIMIT)
                    || (count_next >= {1'b0, chunk_length_q});

  // a held word moves on unless it closes a chunk into a full result slot
  assign advance    = in_valid_q && (!chunk_close || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_data_q <= in_i.data_byte;
      in_eof_q  <= in_i.end_of_file;
    end
  end

  rspe_lfsr u_lfsr (
    .data_i   (in_data_q),
    .parity_i (parity_q),
    .parity_o (parity_step)
  );

  // parity and count state, cleared when a chunk closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= '0;
      count_q  <= '0;
    end else if (advance) begin
      if (chunk_close) begin
        parity_q <= '0;
        count_q  <= '0;
      end else begin
        parity_q <= parity_step;
        count_q  <= count_next[7:0];
      end
    end
  end

  // result parity, stages without a field drop out, missing stages read zero
  always_comb begin
    for (int j = 0; j < OUT_PARITY; j++) begin
      out_parity_d[j] = '0;
    end
    for (int j = 0; j < PARITY_BYTES; j++) begin
      if (j < OUT_PARITY) begin
        out_parity_d[j] = parity_step[j];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && chunk_close) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && chunk_close) begin
      out_parity_q <= out_parity_d;
      out_bytes_q  <= count_next[7:0];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.parity_first  = out_parity_q[0];
  assign out_o.parity_second = out_parity_q[1];
  assign out_o.parity_third  = out_parity_q[2];
  assign out_o.parity_fourth = out_parity_q[3];
  assign out_o.chunk_bytes   = out_bytes_q;

endmodule

`default_nettype wire

/* src/rspe_lfsr.sv */
// one step of the parity lfsr: constant gf multipliers and xor
// depends on rspe_pkg
`default_nettype none

module rspe_lfsr
  import rspe_pkg::*;
(
  input  byte_t   data_i,
  input  parity_t parity_i,
  output parity_t parity_o
);

  byte_t fb;

  // feedback is the incoming byte plus the head stage
  assign fb = data_i ^ parity_i[0];

  // shift toward stage 0, adding the scaled feedback
  always_comb begin
    for (int j = 0; j < PARITY_BYTES - 1; j++) begin
      parity_o[j] = parity_i[j+1] ^ gf_mul(GEN_COEF[j+1], fb);
    end
    parity_o[PARITY_BYTES-1] = gf_mul(GEN_COEF[PARITY_BYTES], fb);
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
// testbench for reed_solomon_parity_encoder: random and directed byte streams,
// parity predicted in gf(256) and checked word by word on the result channel
// depends on rspe_pkg, rspe_in_if, rspe_out_if and the encoder rtl
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rspe_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 100000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 64;
  localparam int unsigned RESET_CYCLES  = 12;

  typedef struct packed {
    byte_t [3:0] parity;
    byte_t       chunk_bytes;
  } parity_word_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  cfg_we_i    = 1'b0;
  byte_t cfg_wdata_i = '0;

  rspe_in_if  in_bus ();
  rspe_out_if out_bus ();

  reed_solomon_parity_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // encoder state as predicted
  byte_t        gen_coef [0:PARITY_BYTES];
  byte_t        lfsr_q   [0:PARITY_BYTES-1];
  int unsigned  chunk_fill;
  byte_t        chunk_len_cfg;
  parity_word_t expected_parity [$];

  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_request = 0;
  bit          full_rate    = 1'b0;

  // clock
  always #4 clk_i = ~clk_i;

  // gf(256) product, msb first with reduction by the field polynomial
  function automatic byte_t gf_times(input byte_t a, input byte_t b);
    byte_t acc;
    acc = '0;
    for (int k = 7; k >= 0; k--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_POLY[7:0] : 8'h00);
      if (b[k]) begin
        acc ^= a;
      end
    end
    return acc;
  endfunction

  // generator coefficients: product of (x - alpha^i)
  task automatic build_generator();
    byte_t root;
    root = 8'h01;
    gen_coef[0] = 8'h01;
    for (int i = 1; i <= PARITY_BYTES; i++) begin
      gen_coef[i] = '0;
    end
    for (int i = 0; i < PARITY_BYTES; i++) begin
      for (int j = i + 1; j > 0; j--) begin
        gen_coef[j] ^= gf_times(gen_coef[j-1], root);
      end
      root = gf_times(root, 8'h02);
    end
  endtask

  task automatic clear_chunk();
    for (int j = 0; j < PARITY_BYTES; j++) begin
      lfsr_q[j] = '0;
    end
    chunk_fill = 0;
  endtask

  // one lfsr step; a closing byte queues the parity word it produces
  task automatic encode_byte(input byte_t data, input logic eof);
    byte_t        fb;
    int unsigned  cnt;
    parity_word_t word;
    fb = data ^ lfsr_q[0];
    for (int j = 0; j < PARITY_BYTES - 1; j++) begin
      lfsr_q[j] = lfsr_q[j+1] ^ gf_times(gen_coef[j+1], fb);
    end
    lfsr_q[PARITY_BYTES-1] = gf_times(gen_coef[PARITY_BYTES], fb);
    cnt = chunk_fill + 1;
    if (cnt >= 255 || cnt >= chunk_len_cfg || eof) begin
      for (int j = 0; j < 4; j++) begin
        word.parity[j] = (j < PARITY_BYTES) ? lfsr_q[j] : 8'h00;
      end
      word.chunk_bytes = byte_t'(cnt);
      expected_parity.push_back(word);
      clear_chunk();
    end else begin
      chunk_fill = cnt;
    end
  endtask

  // offer one word after a random gap and wait for it to be taken
  task automatic send_byte(input byte_t data, input logic eof);
    int unsigned gap;
    gap = full_rate ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.data_byte   <= data;
    in_bus.end_of_file <= eof;
    do @(posedge clk_i); while (!in_bus.ready);
    encode_byte(data, eof);
  endtask

  // random content, end of file with odds 1 in eof_odds (0: never)
  task automatic send_random_bytes(input int unsigned count, input int unsigned eof_odds);
    logic eof;
    for (int unsigned i = 0; i < count; i++) begin
      eof = (eof_odds != 0) && ($urandom_range(eof_odds - 1, 0) == 0);
      send_byte(byte_t'($urandom_range(255, 0)), eof);
    end
  endtask

  // stop offering, let every expected word arrive, then let the pipe settle
  task automatic drain();
    in_bus.valid <= 1'b0;
    wait (expected_parity.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_chunk_length(input byte_t len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    chunk_len_cfg = len;
  endtask

  // extremes of the data byte, chunks closed by end of file
  task automatic test_eof_close();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // length after reset is 239; leaves a few bytes of an open chunk
  task automatic test_reset_length();
    send_random_bytes(245, 0);
  endtask

  // length lowered below the open chunk, zero acting as one, one and max
  task automatic test_length_edges();
    drain();
    write_chunk_length(8'd2);
    send_byte(8'h5a, 1'b0);
    drain();
    write_chunk_length(8'd0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    drain();
    write_chunk_length(8'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    drain();
    write_chunk_length(8'd255);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_byte(8'h7e, 1'b1);
  endtask

  // a full 255-byte chunk
  task automatic test_max_chunk();
    send_random_bytes(258, 0);
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    drain();
    write_chunk_length(8'd1);
    full_rate    = 1'b1;
    hold_request = LONG_HOLD;
    send_random_bytes(24, 0);
    full_rate    = 1'b0;
  endtask

  // random streams over a spread of lengths, one stretch at full rate
  task automatic test_random_lengths();
    byte_t lens [6];
    lens = '{8'd3, 8'd2, byte_t'($urandom_range(40, 4)), 8'd17,
             byte_t'($urandom_range(254, 1)), 8'd64};
    foreach (lens[i]) begin
      drain();
      write_chunk_length(lens[i]);
      full_rate = (i == 3);
      send_random_bytes(25, 8);
    end
    full_rate = 1'b0;
  endtask

  // result sink: random stalls, long hold on request
  initial begin : result_sink
    int unsigned stall;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = full_rate ? 0 : $urandom_range(3, 0);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid && hold_request == 0);
    end
  end

  function automatic void check_field(input string name, input byte_t want, input byte_t got);
    if (want !== got) begin
      $error("%s: expected %02h, actual %02h", name, want, got);
      error_count++;
    end
  endfunction

  // compare each result word with the oldest expected one
  always @(posedge clk_i) begin : result_check
    parity_word_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_parity.size() == 0) begin
        $error("unexpected word: chunk_bytes %0d", out_bus.chunk_bytes);
        error_count++;
      end else begin
        want = expected_parity.pop_front();
        check_field("parity_first", want.parity[0], out_bus.parity_first);
        check_field("parity_second", want.parity[1], out_bus.parity_second);
        check_field("parity_third", want.parity[2], out_bus.parity_third);
        check_field("parity_fourth", want.parity[3], out_bus.parity_fourth);
        check_field("chunk_bytes", want.chunk_bytes, out_bus.chunk_bytes);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // test sequence
  initial begin
    in_bus.valid       = 1'b0;
    in_bus.data_byte   = '0;
    in_bus.end_of_file = 1'b0;
    build_generator();
    clear_chunk();
    chunk_len_cfg = LENGTH_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_eof_close();
    test_reset_length();
    test_length_edges();
    test_max_chunk();
    test_backpressure();
    test_random_lengths();
    drain();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
